// File: hw/rtl/psn_pkg.sv
// Shared types, codes and effect tables for the sound-effect note sequencer.
// No dependencies; every other file of the block imports this package.
package psn_pkg;

    localparam int KIND_W    = 3;
    localparam int MASK_W    = 3;
    localparam int CH_W      = 4;
    localparam int PATCH_W   = 3;
    localparam int NOTE_W    = 7;
    localparam int VOL_W     = 7;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int SLOTS     = 4;
    localparam int SLOT_W    = 2;

    localparam int PSN_QUEUE_DEPTH = 2;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_TICK     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_JUMP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CHARGE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SHARD    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TERMINUS = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SHIELD   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACKER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUSHER    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GHOST     = 2'd3;

    // player effects
    localparam logic [1:0] EFF_CHARGE   = 2'd0;
    localparam logic [1:0] EFF_SHARD    = 2'd1;
    localparam logic [1:0] EFF_TERMINUS = 2'd2;
    localparam logic [1:0] EFF_SHIELD   = 2'd3;

    // synth channels
    localparam logic [CH_W-1:0] CH_JUMP   = 4'd5;
    localparam logic [CH_W-1:0] CH_GROUND = 4'd6;
    localparam logic [CH_W-1:0] CH_GHOST  = 4'd7;
    localparam logic [CH_W-1:0] CH_PLAYER = 4'd8;

    // command actions
    localparam logic ACT_NOTE_ON = 1'b0;
    localparam logic ACT_STOP    = 1'b1;

    // patches
    localparam logic [PATCH_W-1:0] PATCH_JUMP    = 3'd0;
    localparam logic [PATCH_W-1:0] PATCH_CHARGE  = 3'd1;
    localparam logic [PATCH_W-1:0] PATCH_SHARD   = 3'd2;
    localparam logic [PATCH_W-1:0] PATCH_TERM    = 3'd3;
    localparam logic [PATCH_W-1:0] PATCH_IMPACT  = 3'd4;
    localparam logic [PATCH_W-1:0] PATCH_RUSHER  = 3'd5;
    localparam logic [PATCH_W-1:0] PATCH_TRACKER = 3'd6;
    localparam logic [PATCH_W-1:0] PATCH_GHOST   = 3'd7;

    localparam logic [VOL_W-1:0]  JUMP_VOL      = 7'd90;
    localparam logic [NOTE_W-1:0] TRACKER_NOTE  = 7'd36;
    localparam logic [VOL_W-1:0]  TRACKER_VOL   = 7'd70;
    localparam logic [NOTE_W-1:0] RUSHER_NOTE   = 7'd84;
    localparam logic [VOL_W-1:0]  RUSHER_VOL    = 7'd60;
    localparam logic [NOTE_W-1:0] GHOST_NOTE_HI = 7'd62;
    localparam logic [NOTE_W-1:0] GHOST_NOTE_LO = 7'd58;
    localparam logic [VOL_W-1:0]  GHOST_VOL     = 7'd65;

    // command slots, in output order
    localparam logic [SLOT_W-1:0] SLOT_JUMP   = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_PLAYER = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_GROUND = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_GHOST  = 2'd3;

    typedef enum logic [1:0] {
        CLS_TICK,
        CLS_JUMP,
        CLS_PLAYER,
        CLS_NONE
    } t_cls;

    typedef struct packed {
        t_cls              cls;
        logic [1:0]        effect;
        logic [MASK_W-1:0] mask;
    } t_item;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic               action;
        logic [PATCH_W-1:0] patch;
        logic [NOTE_W-1:0]  note;
        logic [VOL_W-1:0]   volume;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic [CFG_W-1:0] jump_step;
        logic [CFG_W-1:0] tracker_period;
        logic [CFG_W-1:0] rusher_period;
        logic [CFG_W-1:0] ghost_period;
    } t_cfg;

    function automatic logic [CFG_W-1:0] eff_period(input logic [CFG_W-1:0] p);
        return (p == '0) ? CFG_W'(1) : p;
    endfunction

    function automatic logic [NOTE_W-1:0] jump_note(input logic [1:0] idx);
        case (idx)
            2'd0:    return 7'd72;
            2'd1:    return 7'd78;
            2'd2:    return 7'd84;
            default: return 7'd0;
        endcase
    endfunction

    function automatic logic [PATCH_W-1:0] eff_patch(input logic [1:0] e);
        case (e)
            EFF_CHARGE:   return PATCH_CHARGE;
            EFF_SHARD:    return PATCH_SHARD;
            EFF_TERMINUS: return PATCH_TERM;
            default:      return PATCH_IMPACT;
        endcase
    endfunction

    function automatic logic [VOL_W-1:0] eff_volume(input logic [1:0] e);
        case (e)
            EFF_CHARGE:   return 7'd90;
            EFF_SHARD:    return 7'd95;
            EFF_TERMINUS: return 7'd110;
            default:      return 7'd127;
        endcase
    endfunction

    function automatic logic [3:0] eff_ticks(input logic [1:0] e);
        case (e)
            EFF_CHARGE:   return 4'd5;
            EFF_SHARD:    return 4'd4;
            EFF_TERMINUS: return 4'd6;
            default:      return 4'd8;
        endcase
    endfunction

    function automatic logic [2:0] eff_count(input logic [1:0] e);
        case (e)
            EFF_CHARGE:   return 3'd3;
            EFF_SHARD:    return 3'd4;
            EFF_TERMINUS: return 3'd5;
            default:      return 3'd2;
        endcase
    endfunction

    function automatic logic [NOTE_W-1:0] eff_note(input logic [1:0] e,
                                                   input logic [2:0] idx);
        case (e)
            EFF_CHARGE: begin
                case (idx)
                    3'd0:    return 7'd65;
                    3'd1:    return 7'd69;
                    3'd2:    return 7'd72;
                    default: return 7'd0;
                endcase
            end
            EFF_SHARD: begin
                case (idx)
                    3'd0:    return 7'd65;
                    3'd1:    return 7'd69;
                    3'd2:    return 7'd72;
                    3'd3:    return 7'd76;
                    default: return 7'd0;
                endcase
            end
            EFF_TERMINUS: begin
                case (idx)
                    3'd0:    return 7'd60;
                    3'd1:    return 7'd64;
                    3'd2:    return 7'd67;
                    3'd3:    return 7'd71;
                    3'd4:    return 7'd76;
                    default: return 7'd0;
                endcase
            end
            default: begin
                case (idx)
                    3'd0:    return 7'd55;
                    3'd1:    return 7'd43;
                    default: return 7'd0;
                endcase
            end
        endcase
    endfunction

    function automatic t_cmd note_cmd(input logic [CH_W-1:0] ch,
                                      input logic [PATCH_W-1:0] patch,
                                      input logic [NOTE_W-1:0] note,
                                      input logic [VOL_W-1:0] vol);
        t_cmd c;
        c.channel = ch;
        c.action  = ACT_NOTE_ON;
        c.patch   = patch;
        c.note    = note;
        c.volume  = vol;
        c.last    = 1'b0;
        return c;
    endfunction

    function automatic t_cmd stop_cmd(input logic [CH_W-1:0] ch);
        t_cmd c;
        c.channel = ch;
        c.action  = ACT_STOP;
        c.patch   = '0;
        c.note    = '0;
        c.volume  = '0;
        c.last    = 1'b0;
        return c;
    endfunction

endpackage

// File: hw/rtl/psn_if.sv
// Handshake interfaces of the sequencer: input items, synth commands, config writes.
// Depends on psn_pkg for field widths.
interface psn_item_if import psn_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [MASK_W-1:0] threat_mask;

    modport source (output valid, kind, threat_mask, input ready);
    modport sink   (input valid, kind, threat_mask, output ready);
endinterface

interface psn_cmd_if import psn_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    channel;
    logic               action;
    logic [PATCH_W-1:0] patch;
    logic [NOTE_W-1:0]  note;
    logic [VOL_W-1:0]   volume;
    logic               last;

    modport source (output valid, channel, action, patch, note, volume, last,
                    input ready);
    modport sink   (input valid, channel, action, patch, note, volume, last,
                    output ready);
endinterface

interface psn_cfg_if import psn_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/psn_queue.sv
// Short queue of classified items between front and back.
// Depends on psn_pkg for the item type.
module psn_queue import psn_pkg::*; #(
    parameter int DEPTH = PSN_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_push_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule

// File: hw/rtl/psn_front.sv
// Front end: takes input words and sorts them into tick, jump and player requests.
// Depends on psn_pkg and psn_item_if.
module psn_front import psn_pkg::*; (
    psn_item_if.sink i_item,
    input  logic     i_q_full,
    output logic     o_push,
    output t_item    o_push_item
);
    t_item cls_item;

    always_comb begin
        cls_item.mask   = i_item.threat_mask;
        cls_item.effect = 2'(i_item.kind - KIND_CHARGE);
        case (i_item.kind) inside
            KIND_TICK:                   cls_item.cls = CLS_TICK;
            KIND_JUMP:                   cls_item.cls = CLS_JUMP;
            [KIND_CHARGE:KIND_SHIELD]:   cls_item.cls = CLS_PLAYER;
            default:                     cls_item.cls = CLS_NONE;
        endcase
    end

    // unused kinds are taken and dropped here
    assign i_item.ready = !i_q_full;
    assign o_push       = i_item.valid && !i_q_full && (cls_item.cls != CLS_NONE);
    assign o_push_item  = cls_item;

endmodule

// File: hw/rtl/psn_back.sv
// Back end: voice state, per-item command slots and the output register.
// Depends on psn_pkg and psn_cmd_if.
module psn_back import psn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    output logic       o_q_pop,
    psn_cmd_if.source  o_cmd
);
    // voice state
    logic              r_jump_busy, n_jump_busy;
    logic [1:0]        r_jump_idx, n_jump_idx;
    logic [7:0]        r_jump_timer, n_jump_timer;
    logic              r_pl_busy, n_pl_busy;
    logic [2:0]        r_pl_prio, n_pl_prio;
    logic [2:0]        r_pl_idx, n_pl_idx;
    logic [3:0]        r_pl_timer, n_pl_timer;
    logic [1:0]        r_pl_eff, n_pl_eff;
    logic [7:0]        r_gnd_timer, n_gnd_timer;
    logic [7:0]        r_gho_timer, n_gho_timer;
    logic              r_gho_toggle, n_gho_toggle;
    logic [MASK_W-1:0] r_prev_mask, n_prev_mask;

    // evaluation temporaries
    logic [7:0]        jt, jper, gt, gper, ht, hper;
    logic [3:0]        pt;
    logic [2:0]        pi;
    logic [1:0]        nj;
    logic              trk, rsh;
    t_cmd              ev_cmd [SLOTS];
    logic [SLOTS-1:0]  ev_vld;

    // slots and output register
    t_cmd              r_slot [SLOTS];
    logic [SLOTS-1:0]  r_slot_vld, rem_vld;
    logic [SLOT_W-1:0] first;
    logic              load_out, take;
    logic              r_out_vld;
    t_cmd              r_out;

    always_comb begin
        n_jump_busy  = r_jump_busy;
        n_jump_idx   = r_jump_idx;
        n_jump_timer = r_jump_timer;
        n_pl_busy    = r_pl_busy;
        n_pl_prio    = r_pl_prio;
        n_pl_idx     = r_pl_idx;
        n_pl_timer   = r_pl_timer;
        n_pl_eff     = r_pl_eff;
        n_gnd_timer  = r_gnd_timer;
        n_gho_timer  = r_gho_timer;
        n_gho_toggle = r_gho_toggle;
        n_prev_mask  = r_prev_mask;
        ev_vld       = '0;
        for (int i = 0; i < SLOTS; i++) begin
            ev_cmd[i] = stop_cmd(CH_JUMP);
        end

        jt   = r_jump_timer + 8'd1;
        jper = eff_period(i_cfg.jump_step);
        nj   = r_jump_idx + 2'd1;
        pt   = r_pl_timer + 4'd1;
        pi   = r_pl_idx + 3'd1;
        trk  = i_q_item.mask[1];
        rsh  = i_q_item.mask[0];
        gper = eff_period(trk ? i_cfg.tracker_period : i_cfg.rusher_period);
        gt   = r_gnd_timer + 8'd1;
        hper = eff_period(i_cfg.ghost_period);
        ht   = r_gho_timer + 8'd1;

        case (i_q_item.cls)
            CLS_JUMP: begin
                n_jump_busy  = 1'b1;
                n_jump_idx   = '0;
                n_jump_timer = '0;
                ev_vld[SLOT_JUMP] = 1'b1;
                ev_cmd[SLOT_JUMP] = note_cmd(CH_JUMP, PATCH_JUMP, jump_note(2'd0), JUMP_VOL);
            end
            CLS_PLAYER: begin
                // shield always wins; others yield to a higher effect in play
                if (i_q_item.effect == EFF_SHIELD ||
                    !(r_pl_busy && r_pl_prio > ({1'b0, i_q_item.effect} + 3'd1))) begin
                    n_pl_busy  = 1'b1;
                    n_pl_eff   = i_q_item.effect;
                    n_pl_prio  = {1'b0, i_q_item.effect} + 3'd1;
                    n_pl_idx   = '0;
                    n_pl_timer = '0;
                    ev_vld[SLOT_PLAYER] = 1'b1;
                    ev_cmd[SLOT_PLAYER] = note_cmd(CH_PLAYER, eff_patch(i_q_item.effect),
                                                   eff_note(i_q_item.effect, 3'd0),
                                                   eff_volume(i_q_item.effect));
                end
            end
            CLS_TICK: begin
                if (r_jump_busy) begin
                    if (jt >= jper) begin
                        n_jump_timer = '0;
                        ev_vld[SLOT_JUMP] = 1'b1;
                        if (nj == 2'd3) begin
                            n_jump_busy = 1'b0;
                            n_jump_idx  = 2'd3;
                            ev_cmd[SLOT_JUMP] = stop_cmd(CH_JUMP);
                        end else begin
                            n_jump_idx = nj;
                            ev_cmd[SLOT_JUMP] = note_cmd(CH_JUMP, PATCH_JUMP,
                                                         jump_note(nj), JUMP_VOL);
                        end
                    end else begin
                        n_jump_timer = jt;
                    end
                end
                if (r_pl_busy) begin
                    if (pt >= eff_ticks(r_pl_eff)) begin
                        n_pl_timer = '0;
                        n_pl_idx   = pi;
                        ev_vld[SLOT_PLAYER] = 1'b1;
                        if (pi >= eff_count(r_pl_eff)) begin
                            n_pl_busy = 1'b0;
                            n_pl_prio = '0;
                            ev_cmd[SLOT_PLAYER] = stop_cmd(CH_PLAYER);
                        end else begin
                            ev_cmd[SLOT_PLAYER] = note_cmd(CH_PLAYER, eff_patch(r_pl_eff),
                                                           eff_note(r_pl_eff, pi),
                                                           eff_volume(r_pl_eff));
                        end
                    end else begin
                        n_pl_timer = pt;
                    end
                end
                if (trk || rsh) begin
                    if (gt >= gper) begin
                        n_gnd_timer = '0;
                        ev_vld[SLOT_GROUND] = 1'b1;
                        ev_cmd[SLOT_GROUND] = trk ?
                            note_cmd(CH_GROUND, PATCH_TRACKER, TRACKER_NOTE, TRACKER_VOL) :
                            note_cmd(CH_GROUND, PATCH_RUSHER, RUSHER_NOTE, RUSHER_VOL);
                    end else begin
                        n_gnd_timer = gt;
                    end
                end else if (r_prev_mask[1:0] != 2'b00) begin
                    n_gnd_timer = '0;
                    ev_vld[SLOT_GROUND] = 1'b1;
                    ev_cmd[SLOT_GROUND] = stop_cmd(CH_GROUND);
                end
                if (i_q_item.mask[2]) begin
                    if (ht >= hper) begin
                        n_gho_timer  = '0;
                        n_gho_toggle = !r_gho_toggle;
                        ev_vld[SLOT_GHOST] = 1'b1;
                        ev_cmd[SLOT_GHOST] = note_cmd(CH_GHOST, PATCH_GHOST,
                            (!r_gho_toggle) ? GHOST_NOTE_HI : GHOST_NOTE_LO, GHOST_VOL);
                    end else begin
                        n_gho_timer = ht;
                    end
                end else if (r_prev_mask[2]) begin
                    n_gho_timer  = '0;
                    n_gho_toggle = 1'b0;
                    ev_vld[SLOT_GHOST] = 1'b1;
                    ev_cmd[SLOT_GHOST] = stop_cmd(CH_GHOST);
                end
                n_prev_mask = i_q_item.mask;
            end
            default: ;
        endcase

        // flag the final command of this item
        for (int i = 0; i < SLOTS; i++) begin
            ev_cmd[i].last = ev_vld[i] && ((ev_vld >> (i + 1)) == '0);
        end
    end

    // emitter: lowest pending slot goes to the output register
    always_comb begin
        first = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_slot_vld[i]) begin
                first = SLOT_W'(i);
            end
        end
    end

    assign load_out = !r_out_vld || o_cmd.ready;
    assign take     = load_out && (r_slot_vld != '0);
    assign rem_vld  = take ? (r_slot_vld & ~(SLOTS'(1) << first)) : r_slot_vld;
    assign o_q_pop  = i_q_valid && (rem_vld == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_busy  <= 1'b0;
            r_jump_idx   <= '0;
            r_jump_timer <= '0;
            r_pl_busy    <= 1'b0;
            r_pl_prio    <= '0;
            r_pl_idx     <= '0;
            r_pl_timer   <= '0;
            r_pl_eff     <= '0;
            r_gnd_timer  <= '0;
            r_gho_timer  <= '0;
            r_gho_toggle <= 1'b0;
            r_prev_mask  <= '0;
            r_slot_vld   <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_jump_busy  <= n_jump_busy;
                r_jump_idx   <= n_jump_idx;
                r_jump_timer <= n_jump_timer;
                r_pl_busy    <= n_pl_busy;
                r_pl_prio    <= n_pl_prio;
                r_pl_idx     <= n_pl_idx;
                r_pl_timer   <= n_pl_timer;
                r_pl_eff     <= n_pl_eff;
                r_gnd_timer  <= n_gnd_timer;
                r_gho_timer  <= n_gho_timer;
                r_gho_toggle <= n_gho_toggle;
                r_prev_mask  <= n_prev_mask;
                r_slot_vld   <= ev_vld;
            end else begin
                r_slot_vld   <= rem_vld;
            end
            if (load_out) begin
                r_out_vld <= (r_slot_vld != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_slot[i] <= ev_cmd[i];
            end
        end
        if (take) begin
            r_out <= r_slot[first];
        end
    end

    assign o_cmd.valid   = r_out_vld;
    assign o_cmd.channel = r_out.channel;
    assign o_cmd.action  = r_out.action;
    assign o_cmd.patch   = r_out.patch;
    assign o_cmd.note    = r_out.note;
    assign o_cmd.volume  = r_out.volume;
    assign o_cmd.last    = r_out.last;

`ifndef SYNTHESIS
    a_jump_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_jump_busy |-> r_jump_idx != 2'd3)
        else $error("jump arpeggio busy past its last note");

    a_pl_prio_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pl_busy |-> r_pl_prio == ({1'b0, r_pl_eff} + 3'd1))
        else $error("player priority does not match running effect");

    a_pl_prio_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pl_busy |-> r_pl_prio == 3'd0)
        else $error("player priority held while idle");

    a_pl_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pl_busy |-> r_pl_idx < eff_count(r_pl_eff))
        else $error("player note index beyond effect length");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && o_cmd.ready && !r_out.last |=> r_out_vld)
        else $error("gap inside a command burst");
`endif

endmodule

// File: hw/rtl/priority_sfx_note_sequencer.sv
// Top level of the sound-effect note sequencer: config registers, front, queue, back.
// Depends on psn_pkg, psn_if, psn_front, psn_queue and psn_back.
//
// Four-voice sound-effect command sequencer. Each input word is a tick or a
// trigger; the front classifies it in the cycle it is accepted and drops unused
// kinds, and a QUEUE_DEPTH-entry queue hands it to the back, which updates the
// voice state and loads up to four synth commands (jump, player, ground, ghost,
// in that order) into its command slots at once. The slots drain one command
// a cycle into the output register while that register is empty or being
// taken, so an item holds the back until all of its commands have left the
// slots, and an item with no command still passes through. The next item is
// taken from the queue in the cycle the last slot drains, so the output
// register can hold a command while further words are accepted. The first
// command of a word passes through the queue, a command slot and the output
// register before it is offered.
// Config writes are taken every cycle and should arrive only when the block is
// idle; a period written as zero acts as one.
module priority_sfx_note_sequencer import psn_pkg::*; #(
    parameter int QUEUE_DEPTH = PSN_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psn_item_if.sink   i_item,
    psn_cmd_if.source  o_cmd,
    psn_cfg_if.sink    i_cfg
);
    t_cfg  r_cfg;
    logic  q_push, q_full, q_pop, q_valid;
    t_item q_push_item, q_item;

    // config registers: always ready, hold until written
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.jump_step      <= 8'd5;
            r_cfg.tracker_period <= 8'd20;
            r_cfg.rusher_period  <= 8'd8;
            r_cfg.ghost_period   <= 8'd6;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_JUMP_STEP: r_cfg.jump_step      <= i_cfg.data;
                CFG_TRACKER:   r_cfg.tracker_period <= i_cfg.data;
                CFG_RUSHER:    r_cfg.rusher_period  <= i_cfg.data;
                CFG_GHOST:     r_cfg.ghost_period   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // classify incoming words
    psn_front u_front (
        .i_item      (i_item),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_item (q_push_item)
    );

    // decouple front from back
    psn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_item (q_push_item),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_item      (q_item)
    );

    // advance voices and drain commands
    psn_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_cmd     (o_cmd)
    );

endmodule

// File: test/tb_priority_sfx_note_sequencer.sv
`timescale 1ns / 100ps
// Self-checking testbench for priority_sfx_note_sequencer: directed table, then random words.
// Depends on psn_pkg, psn_if and the RTL of the sequencer.
module tb_priority_sfx_note_sequencer;
    import psn_pkg::*;

    localparam int CLK_HALF         = 2;
    localparam int RESET_CYCLES     = 5;
    localparam int IDLE_PCT         = 7;
    localparam int PHASES           = 6;
    localparam int RANDOM_PER_PHASE = 73;
    localparam int SETTLE_CYCLES    = 32;
    localparam int HOLD_AT          = 60;
    localparam int HOLD_CYCLES      = 80;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DIRECTED_ROWS    = 25;

    // kinds the block has no use for
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    localparam logic [MASK_W-1:0] MASK_RUSHER  = 3'b001;
    localparam logic [MASK_W-1:0] MASK_TRACKER = 3'b010;
    localparam logic [MASK_W-1:0] MASK_GHOST   = 3'b100;
    localparam logic [MASK_W-1:0] MASK_NONE    = 3'b000;
    localparam logic [MASK_W-1:0] MASK_ALL     = 3'b111;

    // note tables of the voices: the jump arpeggio, then the player effects indexed by effect
    localparam logic [NOTE_W-1:0] ARP_NOTES [3] = '{7'd72, 7'd78, 7'd84};
    localparam logic [NOTE_W-1:0] FX_NOTES [4][5] = '{
        '{7'd65, 7'd69, 7'd72, 7'd0,  7'd0},
        '{7'd65, 7'd69, 7'd72, 7'd76, 7'd0},
        '{7'd60, 7'd64, 7'd67, 7'd71, 7'd76},
        '{7'd55, 7'd43, 7'd0,  7'd0,  7'd0}
    };
    localparam logic [3:0]         FX_TICKS [4] = '{4'd5, 4'd4, 4'd6, 4'd8};
    localparam logic [2:0]         FX_LEN   [4] = '{3'd3, 3'd4, 3'd5, 3'd2};
    localparam logic [VOL_W-1:0]   FX_VOL   [4] = '{7'd90, 7'd95, 7'd110, 7'd127};
    localparam logic [PATCH_W-1:0] FX_PATCH [4] = '{PATCH_CHARGE, PATCH_SHARD,
                                                    PATCH_TERM, PATCH_IMPACT};

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] = '{CFG_JUMP_STEP, CFG_TRACKER,
                                                       CFG_RUSHER, CFG_GHOST};

    // single-command answers that can be read straight off the effect list
    localparam t_cmd NO_CMD       = '0;
    localparam t_cmd JUMP_FIRST   = '{CH_JUMP, ACT_NOTE_ON, PATCH_JUMP, 7'd72, JUMP_VOL, 1'b1};
    localparam t_cmd CHARGE_FIRST = '{CH_PLAYER, ACT_NOTE_ON, PATCH_CHARGE, 7'd65, 7'd90, 1'b1};
    localparam t_cmd SHARD_FIRST  = '{CH_PLAYER, ACT_NOTE_ON, PATCH_SHARD, 7'd65, 7'd95, 1'b1};
    localparam t_cmd TERM_FIRST   = '{CH_PLAYER, ACT_NOTE_ON, PATCH_TERM, 7'd60, 7'd110, 1'b1};
    localparam t_cmd SHIELD_FIRST = '{CH_PLAYER, ACT_NOTE_ON, PATCH_IMPACT, 7'd55, 7'd127, 1'b1};

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_SILENT,
        ROW_ONE
    } t_row_check;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [MASK_W-1:0] mask;
        t_row_check        check;
        t_cmd              cmd;
    } t_stim_row;

    // Directed words, run with the reset settings (jump 5, tracker 20, rusher 8,
    // ghost 6). Rows marked ROW_PREDICT are left to the predictor.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{KIND_TICK,     MASK_NONE,    ROW_SILENT,  NO_CMD},       // quiet tick
        '{KIND_SPARE_LO, MASK_ALL,     ROW_SILENT,  NO_CMD},       // unused kinds
        '{KIND_SPARE_HI, MASK_NONE,    ROW_SILENT,  NO_CMD},
        '{KIND_JUMP,     MASK_ALL,     ROW_ONE,     JUMP_FIRST},   // mask ignored
        '{KIND_CHARGE,   MASK_NONE,    ROW_ONE,     CHARGE_FIRST},
        '{KIND_SHARD,    3'b101,       ROW_ONE,     SHARD_FIRST},  // outranks charge
        '{KIND_CHARGE,   MASK_NONE,    ROW_SILENT,  NO_CMD},       // refused
        '{KIND_TERMINUS, MASK_GHOST,   ROW_ONE,     TERM_FIRST},
        '{KIND_CHARGE,   MASK_NONE,    ROW_SILENT,  NO_CMD},
        '{KIND_SHIELD,   MASK_ALL,     ROW_ONE,     SHIELD_FIRST},
        '{KIND_TERMINUS, MASK_NONE,    ROW_SILENT,  NO_CMD},       // shield outranks
        '{KIND_SHIELD,   MASK_NONE,    ROW_ONE,     SHIELD_FIRST}, // restart mid-play
        '{KIND_TICK,     MASK_ALL,     ROW_PREDICT, NO_CMD},
        '{KIND_TICK,     MASK_ALL,     ROW_PREDICT, NO_CMD},
        '{KIND_TICK,     MASK_ALL,     ROW_PREDICT, NO_CMD},
        '{KIND_TICK,     MASK_ALL,     ROW_PREDICT, NO_CMD},
        '{KIND_TICK,     MASK_ALL,     ROW_PREDICT, NO_CMD},
        '{KIND_TICK,     MASK_ALL,     ROW_PREDICT, NO_CMD},
        '{KIND_JUMP,     MASK_NONE,    ROW_ONE,     JUMP_FIRST},   // restart mid-play
        '{KIND_TICK,     3'b011,       ROW_PREDICT, NO_CMD},
        '{KIND_TICK,     MASK_RUSHER,  ROW_PREDICT, NO_CMD},
        '{KIND_TICK,     MASK_NONE,    ROW_PREDICT, NO_CMD},       // ground voice stops
        '{KIND_TICK,     MASK_GHOST,   ROW_PREDICT, NO_CMD},
        '{KIND_TICK,     MASK_NONE,    ROW_PREDICT, NO_CMD},
        '{KIND_TICK,     MASK_TRACKER, ROW_PREDICT, NO_CMD}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    psn_item_if item_bus ();
    psn_cmd_if  cmd_bus ();
    psn_cfg_if  cfg_bus ();

    priority_sfx_note_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_cmd   (cmd_bus),
        .i_cfg   (cfg_bus)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Shadow of the sequencer: settings plus every voice's position and timer.
    t_cfg               settings    = '{8'd5, 8'd20, 8'd8, 8'd6};
    logic               jmp_active  = 1'b0;
    logic [1:0]         jmp_step    = '0;
    logic [7:0]         jmp_count   = '0;
    logic               fx_active   = 1'b0;
    logic [2:0]         fx_rank     = '0;
    logic [2:0]         fx_step     = '0;
    logic [3:0]         fx_count    = '0;
    logic [1:0]         fx_kind     = '0;
    logic [7:0]         drone_count = '0;
    logic [7:0]         ghost_count = '0;
    logic               ghost_flip  = 1'b0;
    logic [MASK_W-1:0]  mask_seen   = '0;

    t_cmd fresh_cmds[$];    // commands caused by the word just taken
    t_cmd cmd_expected[$];  // commands still owed by the block, oldest first

    int   fail_count = 0;
    int   items_sent = 0;
    logic no_idle    = 1'b0;

    function automatic logic [7:0] period_of(input logic [7:0] p);
        return (p == 8'd0) ? 8'd1 : p;
    endfunction

    // Advance the shadow by one accepted word and collect the commands it causes,
    // in slot order: jump, player, ground, ghost.
    function automatic void predict_item(input logic [KIND_W-1:0] kind,
                                         input logic [MASK_W-1:0] mask);
        logic       trk;
        logic       rsh;
        logic [7:0] per;
        fresh_cmds.delete();
        if (kind == KIND_JUMP) begin
            jmp_active = 1'b1;
            jmp_step   = '0;
            jmp_count  = '0;
            fresh_cmds.push_back('{CH_JUMP, ACT_NOTE_ON, PATCH_JUMP, ARP_NOTES[0],
                                   JUMP_VOL, 1'b0});
        end else if (kind >= KIND_CHARGE && kind <= KIND_SHIELD) begin
            // shield always starts; the rest yield to a higher effect at play
            if (kind == KIND_SHIELD || !(fx_active && fx_rank > 3'(kind - 3'd1))) begin
                fx_active = 1'b1;
                fx_kind   = 2'(kind - KIND_CHARGE);
                fx_rank   = {1'b0, fx_kind} + 3'd1;
                fx_step   = '0;
                fx_count  = '0;
                fresh_cmds.push_back('{CH_PLAYER, ACT_NOTE_ON, FX_PATCH[fx_kind],
                                       FX_NOTES[fx_kind][0], FX_VOL[fx_kind], 1'b0});
            end
        end else if (kind == KIND_TICK) begin
            if (jmp_active) begin
                jmp_count = jmp_count + 8'd1;
                if (jmp_count >= period_of(settings.jump_step)) begin
                    jmp_count = '0;
                    jmp_step  = jmp_step + 2'd1;
                    if (jmp_step == 2'd3) begin
                        jmp_active = 1'b0;
                        fresh_cmds.push_back('{CH_JUMP, ACT_STOP, 3'd0, 7'd0, 7'd0, 1'b0});
                    end else begin
                        fresh_cmds.push_back('{CH_JUMP, ACT_NOTE_ON, PATCH_JUMP,
                                               ARP_NOTES[jmp_step], JUMP_VOL, 1'b0});
                    end
                end
            end
            if (fx_active) begin
                fx_count = fx_count + 4'd1;
                if (fx_count >= FX_TICKS[fx_kind]) begin
                    fx_count = '0;
                    fx_step  = fx_step + 3'd1;
                    if (fx_step >= FX_LEN[fx_kind]) begin
                        fx_active = 1'b0;
                        fx_rank   = '0;
                        fresh_cmds.push_back('{CH_PLAYER, ACT_STOP, 3'd0, 7'd0, 7'd0, 1'b0});
                    end else begin
                        fresh_cmds.push_back('{CH_PLAYER, ACT_NOTE_ON, FX_PATCH[fx_kind],
                                               FX_NOTES[fx_kind][fx_step],
                                               FX_VOL[fx_kind], 1'b0});
                    end
                end
            end
            // ground voice: tracker wins over rusher, stop once both have left
            trk = (mask & MASK_TRACKER) != '0;
            rsh = (mask & MASK_RUSHER) != '0;
            if (trk || rsh) begin
                per = period_of(trk ? settings.tracker_period : settings.rusher_period);
                drone_count = drone_count + 8'd1;
                if (drone_count >= per) begin
                    drone_count = '0;
                    if (trk)
                        fresh_cmds.push_back('{CH_GROUND, ACT_NOTE_ON, PATCH_TRACKER,
                                               TRACKER_NOTE, TRACKER_VOL, 1'b0});
                    else
                        fresh_cmds.push_back('{CH_GROUND, ACT_NOTE_ON, PATCH_RUSHER,
                                               RUSHER_NOTE, RUSHER_VOL, 1'b0});
                end
            end else if ((mask_seen & (MASK_TRACKER | MASK_RUSHER)) != '0) begin
                fresh_cmds.push_back('{CH_GROUND, ACT_STOP, 3'd0, 7'd0, 7'd0, 1'b0});
                drone_count = '0;
            end
            // ghost voice alternates between its two notes
            if ((mask & MASK_GHOST) != '0) begin
                ghost_count = ghost_count + 8'd1;
                if (ghost_count >= period_of(settings.ghost_period)) begin
                    ghost_count = '0;
                    ghost_flip  = ~ghost_flip;
                    fresh_cmds.push_back('{CH_GHOST, ACT_NOTE_ON, PATCH_GHOST,
                                           ghost_flip ? GHOST_NOTE_HI : GHOST_NOTE_LO,
                                           GHOST_VOL, 1'b0});
                end
            end else if ((mask_seen & MASK_GHOST) != '0) begin
                fresh_cmds.push_back('{CH_GHOST, ACT_STOP, 3'd0, 7'd0, 7'd0, 1'b0});
                ghost_count = '0;
                ghost_flip  = 1'b0;
            end
            mask_seen = mask;
        end
        if (fresh_cmds.size() > 0)
            fresh_cmds[fresh_cmds.size() - 1].last = 1'b1;
    endfunction

    // Offer one word, hold it until taken, then book what it owes. Rows of the
    // directed table marked ROW_ONE or ROW_SILENT replace the predicted answer with their own.
    task automatic play_item(input logic [KIND_W-1:0] kind, input logic [MASK_W-1:0] mask,
                             input t_row_check check, input t_cmd typed);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            item_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_bus.valid       <= 1'b1;
        item_bus.kind        <= kind;
        item_bus.threat_mask <= mask;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        items_sent++;
        predict_item(kind, mask);
        if (check != ROW_PREDICT) begin
            fresh_cmds.delete();
            if (check == ROW_ONE)
                fresh_cmds.push_back(typed);
        end
        foreach (fresh_cmds[k])
            cmd_expected.push_back(fresh_cmds[k]);
    endtask

    // Drop valid, wait for every owed command, then let words with no command
    // clear the queue and the back end before touching the registers.
    task automatic drain_commands();
        item_bus.valid <= 1'b0;
        while (cmd_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers back to back; valid stays high between writes.
    task automatic load_settings(input t_cfg setting);
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     value;
        for (int r = 0; r < 4; r++) begin
            idx = REG_ORDER[r];
            case (idx)
                CFG_JUMP_STEP: value = setting.jump_step;
                CFG_TRACKER:   value = setting.tracker_period;
                CFG_RUSHER:    value = setting.rusher_period;
                default:       value = setting.ghost_period;
            endcase
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx;
            cfg_bus.data  <= value;
            @(posedge i_clk);
            while (!cfg_bus.ready) @(posedge i_clk);
        end
        cfg_bus.valid <= 1'b0;
        // the block is idle, so the whole set takes effect at once
        settings = setting;
    endtask

    // Output side: mostly ready, a few random stalls, one long hold-off once the
    // sender is well under way so that the queue fills and input is pushed back.
    initial begin : cmd_ready_gen
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        cmd_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && items_sent >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                cmd_bus.ready <= 1'b0;
            end else begin
                cmd_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare every command taken with the oldest one owed, field by field.
    always @(posedge i_clk) begin : cmd_check
        t_cmd want;
        t_cmd got;
        if (i_rst_n && cmd_bus.valid && cmd_bus.ready) begin
            got = '{cmd_bus.channel, cmd_bus.action, cmd_bus.patch,
                    cmd_bus.note, cmd_bus.volume, cmd_bus.last};
            if (cmd_expected.size() == 0) begin
                $error("unexpected command: channel %0d action %0d", got.channel, got.action);
                fail_count++;
            end else begin
                want = cmd_expected.pop_front();
                if (got.channel !== want.channel) begin
                    $error("channel: expected %0d, actual %0d", want.channel, got.channel);
                    fail_count++;
                end
                if (got.action !== want.action) begin
                    $error("action: expected %0d, actual %0d", want.action, got.action);
                    fail_count++;
                end
                if (got.patch !== want.patch) begin
                    $error("patch: expected %0d, actual %0d", want.patch, got.patch);
                    fail_count++;
                end
                if (got.note !== want.note) begin
                    $error("note: expected %0d, actual %0d", want.note, got.note);
                    fail_count++;
                end
                if (got.volume !== want.volume) begin
                    $error("volume: expected %0d, actual %0d", want.volume, got.volume);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake or a command never delivered ends up here.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // Stimulus: reset, the directed table, then six phases of random words, each
    // under its own settings (reset values, all 255, all 1, all 0, small, wide).
    initial begin : stimulus
        t_cfg              phase_cfg;
        int                n;
        int                tick_run;
        int                r;
        logic [KIND_W-1:0] kind;
        logic [MASK_W-1:0] mask;
        logic [MASK_W-1:0] drone_mask;

        item_bus.valid       <= 1'b0;
        item_bus.kind        <= KIND_TICK;
        item_bus.threat_mask <= MASK_NONE;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.index        <= CFG_JUMP_STEP;
        cfg_bus.data         <= '0;
        i_rst_n              <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tick_run   = 0;
        drone_mask = MASK_NONE;
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain_commands();
                case (ph)
                    1: phase_cfg = '{8'd255, 8'd255, 8'd255, 8'd255};
                    2: phase_cfg = '{8'd1, 8'd1, 8'd1, 8'd1};
                    3: phase_cfg = '{8'd0, 8'd0, 8'd0, 8'd0};
                    4: phase_cfg = '{CFG_W'($urandom_range(1, 16)),
                                     CFG_W'($urandom_range(1, 16)),
                                     CFG_W'($urandom_range(1, 16)),
                                     CFG_W'($urandom_range(1, 16))};
                    default: phase_cfg = '{CFG_W'($urandom_range(0, 255)),
                                           CFG_W'($urandom_range(0, 255)),
                                           CFG_W'($urandom_range(0, 255)),
                                           CFG_W'($urandom_range(0, 255))};
                endcase
                load_settings(phase_cfg);
            end
            // hold one phase free of idling on both sides
            no_idle = (ph == 2);
            if (ph == 0) begin
                foreach (directed_rows[i])
                    play_item(directed_rows[i].kind, directed_rows[i].mask,
                              directed_rows[i].check, directed_rows[i].cmd);
            end
            n = 0;
            while (n < RANDOM_PER_PHASE) begin
                // after a trigger, often run a burst of ticks so that sequences
                // reach their later notes and their stop
                if (tick_run > 0) begin
                    kind = KIND_TICK;
                    tick_run--;
                end else begin
                    r = $urandom_range(99);
                    if (r < 60)      kind = KIND_TICK;
                    else if (r < 68) kind = KIND_JUMP;
                    else if (r < 75) kind = KIND_CHARGE;
                    else if (r < 82) kind = KIND_SHARD;
                    else if (r < 89) kind = KIND_TERMINUS;
                    else if (r < 95) kind = KIND_SHIELD;
                    else             kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
                    if (kind != KIND_TICK && kind <= KIND_SHIELD && $urandom_range(1) == 1)
                        tick_run = $urandom_range(4, 30);
                end
                // keep the enemy mask mostly steady so drones get to fire
                if ($urandom_range(99) < 12)
                    drone_mask = MASK_W'($urandom_range(7));
                mask = (kind == KIND_TICK) ? drone_mask : MASK_W'($urandom_range(7));
                play_item(kind, mask, ROW_PREDICT, NO_CMD);
                if (kind <= KIND_SHIELD)
                    n++;
            end
        end

        drain_commands();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
